// ===== hdl/nfd_pkg.sv =====
package nfd_pkg;

  localparam int PAIRS_PER_FRAME = 128;
  localparam int INTERLEAVE      = 8;
  localparam int SAMPLE_BITS     = 10;

  localparam int CHANNELS  = 2 * PAIRS_PER_FRAME;
  localparam int ROWS      = PAIRS_PER_FRAME / INTERLEAVE;
  localparam int PAIR_BITS = $clog2(PAIRS_PER_FRAME);
  localparam int CHAN_BITS = $clog2(CHANNELS);
  localparam int LANE_AW   = PAIR_BITS + 1;

  typedef struct packed {
    logic                   sync_mark;
    logic [SAMPLE_BITS-1:0] sample_a;
    logic [SAMPLE_BITS-1:0] sample_b;
    logic                   trigger_in;
  } sample_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] value_even;
    logic [SAMPLE_BITS-1:0] value_odd;
    logic [7:0]             channel_index;
    logic                   trigger_echo;
    logic                   sync_error;
    logic                   frame_last;
  } result_t;

  // per-lane store access for one item
  typedef struct packed {
    logic                 we;
    logic                 wbank;
    logic [PAIR_BITS-1:0] waddr;
    logic                 re;
    logic                 rbank;
    logic [PAIR_BITS-1:0] raddr;
  } lane_req_t;

  // lane-local slot of the A value for pair p
  function automatic logic [PAIR_BITS-1:0] write_slot(input logic [PAIR_BITS-1:0] p);
    write_slot = PAIR_BITS'((p % INTERLEAVE) * ROWS + (p / INTERLEAVE));
  endfunction

  // lane holding a channel (A half or B half of its row group)
  function automatic logic chan_lane(input logic [CHAN_BITS-1:0] ch);
    chan_lane = 1'((ch / ROWS) % 2);
  endfunction

  // lane-local slot of a channel
  function automatic logic [PAIR_BITS-1:0] chan_slot(input logic [CHAN_BITS-1:0] ch);
    chan_slot = PAIR_BITS'((ch / (2 * ROWS)) * ROWS + (ch % ROWS));
  endfunction

endpackage

// ===== hdl/nfd_lane.sv =====
module nfd_lane
  import nfd_pkg::*;
(
  input  logic                   clk,
  input  lane_req_t              req,
  input  logic [SAMPLE_BITS-1:0] wdata,
  output logic [SAMPLE_BITS-1:0] rdata_even,
  output logic [SAMPLE_BITS-1:0] rdata_odd
);

  logic [SAMPLE_BITS-1:0] mem [2**LANE_AW];

  logic [LANE_AW-1:0] wa;
  logic [LANE_AW-1:0] ra_even;
  logic [LANE_AW-1:0] ra_odd;

  assign wa      = {req.wbank, req.waddr};
  assign ra_even = {req.rbank, req.raddr};
  // even channel slot has a clear low bit, the odd channel sits right after it
  assign ra_odd  = {req.rbank, req.raddr | PAIR_BITS'(1)};

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[wa] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata_even <= mem[ra_even];
      rdata_odd  <= mem[ra_odd];
    end
  end

endmodule

// ===== hdl/neural_frame_deinterleaver.sv =====
// neural_frame_deinterleaver
// input channel sample/sample_valid/sample_ready carries one converter pair per
// item: sync mark, values A and B, trigger bit. items are dropped until the
// first one with the sync mark set; from then on a free-running pair counter
// (128 pairs per frame) steers A and B into deinterleaved channel slots of a
// ping-pong frame store, and every item yields one result item on
// result/result_valid/result_ready: two consecutive channels of the previous
// frame (zero during the first frame), the even channel number, the trigger
// bit, a sync error flag (pair 0 without sync mark) and a frame-last flag.
// throughput: one item per cycle while the receiver takes results. latency: the result is valid the
// cycle after the input item is accepted (registered read of the store).
// the store is split into two lanes, A-half and B-half channels, each a
// 256-entry memory with one write and two reads per cycle.
// when the receiver stalls, the pending result holds and sample_ready drops
// until it is taken; sample_ready is high whenever the result register is
// empty or being emptied. reset (rst, synchronous) unlocks the block, clears
// the counter and bank select; store contents are not cleared and their
// values are never used before being written.
module neural_frame_deinterleaver
  import nfd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    sample_valid,
  output logic    sample_ready,
  input  sample_t sample,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  // control state
  logic                 locked;
  logic [PAIR_BITS-1:0] pair_count;
  logic                 bank_select;
  logic                 prev_ready;

  // output side fields, aligned with the registered store reads
  logic                 res_lane;
  logic                 res_prev_ok;
  logic [7:0]           res_channel;
  logic                 res_trigger;
  logic                 res_error;
  logic                 res_last;

  logic                 take;
  logic                 produce;
  logic [PAIR_BITS-1:0] pair;
  logic                 last;
  logic [CHAN_BITS-1:0] rd_chan;
  logic                 rd_lane;
  logic [PAIR_BITS-1:0] rd_slot;
  logic [PAIR_BITS-1:0] wr_slot;

  lane_req_t            req [2];
  logic [SAMPLE_BITS-1:0] wdata [2];
  logic [SAMPLE_BITS-1:0] rd_even [2];
  logic [SAMPLE_BITS-1:0] rd_odd [2];

  // accept whenever the result register is free or being drained
  assign sample_ready = !result_valid || result_ready;
  assign take         = sample_valid && sample_ready;
  // before lock only a sync-marked item gets through
  assign produce      = take && (locked || sample.sync_mark);

  assign pair    = locked ? pair_count : '0;
  assign last    = (pair == PAIR_BITS'(PAIRS_PER_FRAME - 1));
  assign rd_chan = {pair, 1'b0};
  assign rd_lane = chan_lane(rd_chan);
  assign rd_slot = chan_slot(rd_chan);
  assign wr_slot = write_slot(pair);

  assign wdata[0] = sample.sample_a;
  assign wdata[1] = sample.sample_b;

  // lane 0 holds the A-half channels, lane 1 the B-half
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      req[i].we    = produce;
      req[i].wbank = bank_select;
      req[i].waddr = wr_slot;
      req[i].re    = produce && (rd_lane == 1'(i));
      req[i].rbank = !bank_select;
      req[i].raddr = rd_slot;
    end
  end

  for (genvar g = 0; g < 2; g++) begin : g_lane
    nfd_lane u_lane (
      .clk        (clk),
      .req        (req[g]),
      .wdata      (wdata[g]),
      .rdata_even (rd_even[g]),
      .rdata_odd  (rd_odd[g])
    );
  end

  // frame counter and bank control
  always_ff @(posedge clk) begin
    if (rst) begin
      locked      <= 1'b0;
      pair_count  <= '0;
      bank_select <= 1'b0;
      prev_ready  <= 1'b0;
    end else if (produce) begin
      locked <= 1'b1;
      if (last) begin
        pair_count  <= '0;
        bank_select <= !bank_select;
        prev_ready  <= 1'b1;
      end else begin
        pair_count <= pair + PAIR_BITS'(1);
      end
    end
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (produce) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  // side fields follow the item, no reset needed
  always_ff @(posedge clk) begin
    if (produce) begin
      res_lane    <= rd_lane;
      res_prev_ok <= prev_ready;
      res_channel <= 8'(rd_chan);
      res_trigger <= sample.trigger_in;
      res_error   <= (pair == '0) && !sample.sync_mark;
      res_last    <= last;
    end
  end

  // merge: pick the lane that served the read, zero while no previous frame
  always_comb begin
    result.value_even    = '0;
    result.value_odd     = '0;
    if (res_prev_ok) begin
      result.value_even = res_lane ? rd_even[1] : rd_even[0];
      result.value_odd  = res_lane ? rd_odd[1]  : rd_odd[0];
    end
    result.channel_index = res_channel;
    result.trigger_echo  = res_trigger;
    result.sync_error    = res_error;
    result.frame_last    = res_last;
  end

`ifndef SYNTHESIS
  a_unlocked_count: assert property (@(posedge clk) disable iff (rst)
    !locked |-> pair_count == '0)
    else $error("pair counter moved before lock");

  a_bank_toggle: assert property (@(posedge clk) disable iff (rst)
    produce && last |=> bank_select != $past(bank_select))
    else $error("bank select did not toggle at frame end");

  a_first_bank: assert property (@(posedge clk) disable iff (rst)
    !prev_ready |-> !bank_select)
    else $error("bank switched before a full frame");

  a_last_channel: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.frame_last |-> result.channel_index == 8'(CHANNELS - 2))
    else $error("frame last on wrong channel");

  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |-> !sample_ready)
    else $error("item accepted while result stalled");
`endif

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import nfd_pkg::*;

  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = '1;

  logic    clk;
  logic    rst;
  logic    sample_valid;
  logic    sample_ready;
  sample_t sample;
  logic    result_valid;
  logic    result_ready;
  result_t result;

  neural_frame_deinterleaver dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  // shadow of the block: lock flag, free-running pair counter, bank select,
  // previous-frame flag and both banks of the frame store
  bit                   is_locked;
  int                   pair_no;
  bit                   wr_bank;
  bit                   prev_ready;
  logic [SAMPLE_BITS-1:0] frame_mem [0:2*CHANNELS-1];

  // readout items predicted but not yet seen on the result channel
  result_t pending_readout[$];

  // knobs shared between the test tasks, send_sample and the receiver process
  bit tx_idle_en;
  bit rx_idle_en;
  int stall_cycles;

  // run statistics
  int items_sent;
  int items_dropped;
  int results_seen;
  int sync_errors_seen;
  int frames_seen;
  int mismatches;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // free-time watchdog, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("timeout with %0d readout items outstanding", pending_readout.size());
    $display("FAILURE");
    $finish;
  end

  // work out the readout item for one accepted input item; returns 0 when the
  // item is dropped because the block has not seen a sync mark yet
  function automatic bit predict_readout(input sample_t s, output result_t r);
    int p;
    int rd;
    int ch;
    r = '0;
    if (!is_locked) begin
      if (!s.sync_mark) return 1'b0;
      is_locked = 1'b1;
      pair_no   = 0;
    end
    p  = pair_no;
    rd = 2 * p;
    r.channel_index = rd[7:0];
    r.trigger_echo  = s.trigger_in;
    r.sync_error    = (p == 0) && !s.sync_mark;
    r.frame_last    = (p == PAIRS_PER_FRAME - 1);
    // previous frame sits in the other bank; zero while the first frame fills
    if (prev_ready) begin
      r.value_even = frame_mem[(wr_bank ? 0 : CHANNELS) + rd];
      r.value_odd  = frame_mem[(wr_bank ? 0 : CHANNELS) + rd + 1];
    end
    // A goes to its deinterleaved channel, B to the same row in the B half
    ch = (p % INTERLEAVE) * (2 * ROWS) + p / INTERLEAVE;
    frame_mem[(wr_bank ? CHANNELS : 0) + ch]        = s.sample_a;
    frame_mem[(wr_bank ? CHANNELS : 0) + ch + ROWS] = s.sample_b;
    if (r.frame_last) begin
      pair_no    = 0;
      wr_bank    = ~wr_bank;
      prev_ready = 1'b1;
    end else begin
      pair_no = p + 1;
    end
    return 1'b1;
  endfunction

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch @%0t: %s", $realtime, msg);
  endtask

  // offer one item, hold it until accepted, then predict its readout
  task automatic send_sample(input sample_t s);
    result_t r;
    if (tx_idle_en && $urandom_range(99) < 22) begin
      sample_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < 22) @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample       <= s;
    @(posedge clk);
    while (!sample_ready) @(posedge clk);
    items_sent++;
    if (predict_readout(s, r)) pending_readout.push_back(r);
    else items_dropped++;
  endtask

  // receiver: random holds, plus a long counted hold-off when a test asks
  initial begin
    result_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_cycles > 0) begin
        result_ready <= 1'b0;
        stall_cycles--;
      end else begin
        result_ready <= !rx_idle_en || ($urandom_range(99) >= 22);
      end
    end
  end

  // result checker: every accepted readout item against the oldest prediction
  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid && result_ready) begin
      results_seen++;
      if (pending_readout.size() == 0) begin
        note_mismatch($sformatf("unexpected readout item ch=%0d", result.channel_index));
      end else begin
        want = pending_readout.pop_front();
        if (result.value_even !== want.value_even || result.value_odd !== want.value_odd ||
            result.channel_index !== want.channel_index ||
            result.trigger_echo !== want.trigger_echo ||
            result.sync_error !== want.sync_error || result.frame_last !== want.frame_last)
          note_mismatch({
            $sformatf("exp ev=%0d od=%0d ch=%0d trg=%0d err=%0d last=%0d",
                      want.value_even, want.value_odd, want.channel_index,
                      want.trigger_echo, want.sync_error, want.frame_last),
            $sformatf(" / got ev=%0d od=%0d ch=%0d trg=%0d err=%0d last=%0d",
                      result.value_even, result.value_odd, result.channel_index,
                      result.trigger_echo, result.sync_error, result.frame_last)});
        if (want.sync_error) sync_errors_seen++;
        if (want.frame_last) frames_seen++;
      end
    end
  end

  // items before the first sync mark must vanish without a readout
  task automatic test_unlocked_drop();
    send_sample('{sync_mark: 1'b0, sample_a: SAMPLE_MAX, sample_b: SAMPLE_MAX, trigger_in: 1'b1});
    send_sample('{sync_mark: 1'b0, sample_a: '0, sample_b: '0, trigger_in: 1'b0});
    send_sample('{sync_mark: 1'b0, sample_a: 10'h2AA, sample_b: 10'h155, trigger_in: 1'b1});
  endtask

  // lock on a sync mark, then field extremes and a stray mid-frame sync
  task automatic test_lock_and_extremes();
    sample_t s;
    send_sample('{sync_mark: 1'b1, sample_a: '0, sample_b: SAMPLE_MAX, trigger_in: 1'b0});
    send_sample('{sync_mark: 1'b0, sample_a: SAMPLE_MAX, sample_b: '0, trigger_in: 1'b1});
    send_sample('{sync_mark: 1'b0, sample_a: 10'h2AA, sample_b: 10'h155, trigger_in: 1'b1});
    send_sample('{sync_mark: 1'b0, sample_a: 10'h155, sample_b: 10'h2AA, trigger_in: 1'b0});
    // sync away from pair 0 is ignored by the free-running counter
    send_sample('{sync_mark: 1'b1, sample_a: SAMPLE_MAX, sample_b: SAMPLE_MAX, trigger_in: 1'b1});
    send_sample('{sync_mark: 1'b0, sample_a: '0, sample_b: '0, trigger_in: 1'b0});
    repeat (4) begin
      s.sync_mark  = 1'b0;
      s.sample_a   = SAMPLE_BITS'($urandom_range(SAMPLE_MAX));
      s.sample_b   = SAMPLE_BITS'($urandom_range(SAMPLE_MAX));
      s.trigger_in = 1'($urandom_range(1));
      send_sample(s);
    end
  endtask

  // mostly well-formed frames (sync exactly at pair 0) with random content;
  // some frames lose their sync mark, and a few items carry a random one
  task automatic test_random_frames(input int n_items);
    sample_t s;
    for (int k = 0; k < n_items; k++) begin
      s.sample_a   = SAMPLE_BITS'($urandom_range(SAMPLE_MAX));
      s.sample_b   = SAMPLE_BITS'($urandom_range(SAMPLE_MAX));
      s.trigger_in = 1'($urandom_range(1));
      if ($urandom_range(99) < 8)
        s.sync_mark = 1'($urandom_range(1));
      else if (pair_no == 0 && $urandom_range(99) < 15)
        s.sync_mark = 1'b0;
      else
        s.sync_mark = (pair_no == 0);
      send_sample(s);
    end
  endtask

  // full-rate stretch: neither side idles
  task automatic test_no_idle_burst();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    test_random_frames(150);
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  // receiver holds off for a long stretch while items keep coming, so the
  // block fills up and must drop sample_ready
  task automatic test_output_backpressure();
    tx_idle_en   = 1'b0;
    stall_cycles = 48;
    test_random_frames(60);
    tx_idle_en   = 1'b1;
  endtask

  initial begin
    is_locked    = 1'b0;
    pair_no      = 0;
    wr_bank      = 1'b0;
    prev_ready   = 1'b0;
    tx_idle_en   = 1'b1;
    rx_idle_en   = 1'b1;
    stall_cycles = 0;
    rst          <= 1'b1;
    sample_valid <= 1'b0;
    sample       <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_unlocked_drop();
    test_lock_and_extremes();
    test_random_frames(240);
    test_no_idle_burst();
    test_output_backpressure();
    test_random_frames(90);
    sample_valid <= 1'b0;

    // drain: each result is registered behind its item, plus receiver holds
    while (pending_readout.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (pending_readout.size() != 0) note_mismatch("readout items never arrived");

    $display("sent %0d items (%0d dropped before lock), checked %0d readout items",
             items_sent, items_dropped, results_seen);
    $display("frames completed %0d, sync errors seen %0d, mismatches %0d",
             frames_seen, sync_errors_seen, mismatches);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
